FILE: src/acu_pkg.sv
// Package for the accumulator CPU execute unit: opcodes, register codes,
// status codes and the decoded-instruction struct. No dependencies.
`default_nettype none
package acu_pkg;

  localparam int unsigned AddrBits = 16;

  typedef enum logic [4:0] {
    OP_LODI = 5'd0, OP_LODA = 5'd1, OP_LORR = 5'd2, OP_STOA = 5'd3,
    OP_STOR = 5'd4, OP_STOI = 5'd5, OP_MOVR = 5'd6, OP_MOVA = 5'd7,
    OP_ADD  = 5'd8, OP_SUB  = 5'd9, OP_NEG  = 5'd10, OP_JMP = 5'd11,
    OP_JMPZ = 5'd12, OP_JMPN = 5'd13, OP_CALL = 5'd14, OP_RET = 5'd15,
    OP_HALT = 5'd16, OP_DUMP = 5'd17, OP_DATA = 5'd18
  } mode_t;

  localparam logic [3:0] REG_AC = 4'd4;
  localparam logic [3:0] REG_SP = 4'd5;
  localparam logic [3:0] REG_BP = 4'd6;
  localparam logic [3:0] REG_PC = 4'd7;

  localparam logic [2:0] OFS_NONE = 3'd0;
  localparam logic [2:0] OFS_PREG = 3'd1;
  localparam logic [2:0] OFS_MREG = 3'd2;
  localparam logic [2:0] OFS_PVAL = 3'd3;
  localparam logic [2:0] OFS_MVAL = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_HALT  = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  localparam logic [0:0] CFG_CODE_START  = 1'b0;
  localparam logic [0:0] CFG_STACK_START = 1'b1;

  localparam logic [15:0] CODE_START_RST  = 16'h0010;
  localparam logic [15:0] STACK_START_RST = 16'h0100;

  typedef struct packed {
    logic [4:0]  mode;
    logic [3:0]  reg_a;
    logic [3:0]  reg_b;
    logic [15:0] imm_value;
    logic [15:0] address;
    logic        indirect;
    logic        base_is_reg;
    logic [2:0]  base_reg;
    logic [2:0]  offset_kind;
    logic [2:0]  offset_reg;
    logic [15:0] offset_value;
  } instr_t;

  // Front-end classification carried with the instruction.
  typedef struct packed {
    instr_t     ins;
    logic       err;
  } decoded_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] next_pc;
    logic [15:0] acc_value;
    logic [15:0] stack_value;
    logic [15:0] frame_value;
  } result_t;

endpackage
`default_nettype wire

FILE: src/acu_if.sv
// Valid/ready channel interfaces for the execute unit.
// Depends on acu_pkg.
`default_nettype none
interface acu_instr_if;
  logic               valid;
  logic               ready;
  acu_pkg::instr_t    data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface acu_result_if;
  logic               valid;
  logic               ready;
  acu_pkg::result_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface acu_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [15:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

FILE: src/acu_front.sv
// Front end: accepts instructions, flags static operand errors, and
// queues them in a two-entry FIFO. Depends on acu_pkg.
`default_nettype none
module acu_front (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  acu_pkg::instr_t        in_data,
  output logic                   q_valid,
  input  wire                    q_ready,
  output acu_pkg::decoded_t      q_data
);
  acu_pkg::decoded_t fifo [2];
  logic       wptr, rptr;
  logic [1:0] count;
  acu_pkg::decoded_t dec;
  logic bad_a, bad_a_ac, bad_b_ac, gen_a, gen_b, bad_ofs;

  always_comb begin
    bad_a    = in_data.reg_a[3];
    bad_a_ac = bad_a || (in_data.reg_a == acu_pkg::REG_AC);
    bad_b_ac = in_data.reg_b[3] || (in_data.reg_b == acu_pkg::REG_AC);
    gen_a    = in_data.reg_a < 4'd4;
    gen_b    = in_data.reg_b < 4'd4;
    bad_ofs  = in_data.offset_kind > acu_pkg::OFS_MVAL;
    dec.ins  = in_data;
    unique case (in_data.mode)
      acu_pkg::OP_LODI: dec.err = bad_a_ac;
      acu_pkg::OP_LODA: dec.err = bad_a_ac || in_data.indirect;
      acu_pkg::OP_LORR: dec.err = bad_a_ac || !in_data.indirect || bad_ofs;
      acu_pkg::OP_STOA: dec.err = bad_a || in_data.indirect;
      acu_pkg::OP_STOR: dec.err = bad_a || !in_data.indirect || bad_ofs;
      acu_pkg::OP_STOI: dec.err = in_data.indirect && bad_ofs;
      acu_pkg::OP_MOVR: dec.err = bad_a || bad_b_ac;
      acu_pkg::OP_MOVA: dec.err = bad_a;
      acu_pkg::OP_ADD, acu_pkg::OP_SUB: dec.err = !gen_a || !gen_b;
      acu_pkg::OP_NEG:  dec.err = !gen_a;
      acu_pkg::OP_JMP, acu_pkg::OP_JMPZ, acu_pkg::OP_JMPN,
      acu_pkg::OP_CALL: dec.err = in_data.indirect;
      acu_pkg::OP_RET, acu_pkg::OP_HALT, acu_pkg::OP_DUMP: dec.err = 1'b0;
      default:          dec.err = 1'b1;
    endcase
  end

  assign in_ready = count != 2'd2;
  assign q_valid  = count != 2'd0;
  assign q_data   = fifo[rptr];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      fifo[wptr] <= dec;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (in_valid && in_ready) wptr <= ~wptr;
      if (q_valid && q_ready)   rptr <= ~rptr;
      count <= count + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
    end
  end
endmodule
`default_nettype wire

FILE: src/acu_back.sv
// Back end: register file, data memory and a two-phase sequencer that
// executes one queued instruction and registers its result.
// Depends on acu_pkg.
`default_nettype none
module acu_back (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    q_valid,
  output logic                   q_ready,
  input  acu_pkg::decoded_t      q_data,
  input  wire                    cfg_we,
  input  wire                    cfg_index,
  input  wire  [15:0]            cfg_wdata,
  output logic                   out_valid,
  input  wire                    out_ready,
  output acu_pkg::result_t       out_data
);
  localparam int unsigned AW = acu_pkg::AddrBits;

  logic [15:0] gen_regs [4];
  logic [15:0] accumulator, stack_ptr, base_ptr, program_counter;
  logic [15:0] code_start, stack_start;
  logic [15:0] data_mem [2**AW];

  // Zeroing pass after reset: one word per cycle over the whole memory.
  logic          clearing;
  logic [AW-1:0] clr_addr;

  // Phase 0 latches the instruction and issues the first memory access
  // (ret also reads the saved PC word); phase 1 finishes with the read
  // data and may issue a second write.
  logic              busy;
  acu_pkg::decoded_t cur;
  logic [15:0]       rdata;
  logic [15:0]       ea, pc1;
  logic              wr_stage1;

  // Memory address/data for phase 0
  logic              m_we;
  logic [AW-1:0]     m_addr;
  logic [15:0]       m_wdata;

  function automatic logic [15:0] rd_reg(
    input logic [3:0] r, input logic [15:0] g0, input logic [15:0] g1,
    input logic [15:0] g2, input logic [15:0] g3, input logic [15:0] ac,
    input logic [15:0] sp, input logic [15:0] bp, input logic [15:0] pc);
    case (r)
      4'd0: return g0;
      4'd1: return g1;
      4'd2: return g2;
      4'd3: return g3;
      4'd4: return ac;
      4'd5: return sp;
      4'd6: return bp;
      4'd7: return pc;
      default: return 16'd0;
    endcase
  endfunction

  logic [15:0] base, oreg, ra_val;
  acu_pkg::instr_t qi;
  logic [15:0] qpc1;

  assign qi   = q_data.ins;
  assign qpc1 = program_counter + 16'd1;

  always_comb begin
    base = qi.base_is_reg ? rd_reg({1'b0, qi.base_reg}, gen_regs[0], gen_regs[1],
             gen_regs[2], gen_regs[3], accumulator, stack_ptr, base_ptr, qpc1)
           : qi.address;
    oreg = rd_reg({1'b0, qi.offset_reg}, gen_regs[0], gen_regs[1], gen_regs[2],
             gen_regs[3], accumulator, stack_ptr, base_ptr, qpc1);
    case (qi.offset_kind)
      acu_pkg::OFS_PREG: ea = base + oreg;
      acu_pkg::OFS_MREG: ea = base - oreg;
      acu_pkg::OFS_PVAL: ea = base + qi.offset_value;
      acu_pkg::OFS_MVAL: ea = base - qi.offset_value;
      default:           ea = base;
    endcase
    ra_val = rd_reg(qi.reg_a, gen_regs[0], gen_regs[1], gen_regs[2],
             gen_regs[3], accumulator, stack_ptr, base_ptr, qpc1);
    m_we    = 1'b0;
    m_addr  = AW'(qi.address);
    m_wdata = ra_val;
    if (!q_data.err) begin
      case (qi.mode)
        acu_pkg::OP_LORR: m_addr = AW'(ea);
        acu_pkg::OP_STOA: m_we = 1'b1;
        acu_pkg::OP_STOR: begin
          m_we = 1'b1;
          m_addr = AW'(ea);
        end
        acu_pkg::OP_STOI: begin
          m_we = 1'b1;
          m_addr = qi.indirect ? AW'(ea) : AW'(qi.address);
          m_wdata = qi.imm_value;
        end
        acu_pkg::OP_CALL: begin
          m_we = 1'b1;
          m_addr = AW'(stack_ptr);
          m_wdata = qpc1;
        end
        acu_pkg::OP_RET: m_addr = AW'(base_ptr);
        default: ;
      endcase
    end
  end

  // Output register frees when taken; back end waits while it is full.
  assign q_ready = !busy && !clearing && (!out_valid || out_ready);
  assign pc1 = program_counter + 16'd1;

  // Second read in phase 0 fetches the saved PC for ret; the phase 1
  // write stores BP for call.
  logic [AW-1:0] m2_addr, r2_addr;
  logic [15:0]   rdata2;
  assign wr_stage1 = busy && !cur.err && cur.ins.mode == acu_pkg::OP_CALL;
  assign m2_addr   = AW'(stack_ptr + 16'd1);
  assign r2_addr   = AW'(base_ptr - 16'd1);

  always_ff @(posedge clk) begin
    if (clearing && !rst) begin
      data_mem[clr_addr] <= 16'd0;
    end else if (q_valid && q_ready) begin
      if (m_we) data_mem[m_addr] <= m_wdata;
      rdata  <= data_mem[m_addr];
      rdata2 <= data_mem[r2_addr];
      cur    <= q_data;
    end else if (wr_stage1) begin
      data_mem[m2_addr] <= base_ptr;
    end
  end

  // Phase 1 register update.
  logic [15:0] g_n [4];
  logic [15:0] ac_n, sp_n, bp_n, pc_n, wv, rav;
  logic [1:0]  st_n;
  acu_pkg::instr_t ci;
  logic        ret_pending;

  assign ci = cur.ins;

  always_comb begin
    for (int i = 0; i < 4; i++) g_n[i] = gen_regs[i];
    ac_n = accumulator;
    sp_n = stack_ptr;
    bp_n = base_ptr;
    pc_n = pc1;
    st_n = acu_pkg::ST_OK;
    wv   = 16'd0;
    rav  = rd_reg(ci.reg_a, gen_regs[0], gen_regs[1], gen_regs[2], gen_regs[3],
             accumulator, stack_ptr, base_ptr, pc1);
    if (cur.err) begin
      st_n = acu_pkg::ST_ERROR;
    end else begin
      unique case (ci.mode)
        acu_pkg::OP_LODI, acu_pkg::OP_LODA, acu_pkg::OP_LORR, acu_pkg::OP_MOVA,
        acu_pkg::OP_MOVR: begin
          case (ci.mode)
            acu_pkg::OP_LODI: wv = ci.imm_value;
            acu_pkg::OP_MOVR: wv = rav;
            acu_pkg::OP_MOVA: wv = accumulator;
            default:          wv = rdata;
          endcase
          case (ci.mode == acu_pkg::OP_MOVR ? ci.reg_b : ci.reg_a)
            4'd0: g_n[0] = wv;
            4'd1: g_n[1] = wv;
            4'd2: g_n[2] = wv;
            4'd3: g_n[3] = wv;
            acu_pkg::REG_SP: sp_n = wv;
            acu_pkg::REG_BP: bp_n = wv;
            acu_pkg::REG_PC: pc_n = wv;
            default: ;
          endcase
        end
        acu_pkg::OP_ADD: ac_n = gen_regs[ci.reg_a[1:0]] + gen_regs[ci.reg_b[1:0]];
        acu_pkg::OP_SUB: ac_n = gen_regs[ci.reg_a[1:0]] - gen_regs[ci.reg_b[1:0]];
        acu_pkg::OP_NEG: g_n[ci.reg_a[1:0]] = 16'd0 - gen_regs[ci.reg_a[1:0]];
        acu_pkg::OP_JMP: pc_n = ci.address;
        acu_pkg::OP_JMPZ: if (accumulator == 16'd0) pc_n = ci.address;
        acu_pkg::OP_JMPN: if (accumulator[15]) pc_n = ci.address;
        acu_pkg::OP_CALL: begin
          pc_n = ci.address;
          bp_n = stack_ptr + 16'd1;
          sp_n = stack_ptr + 16'd2;
        end
        acu_pkg::OP_RET: begin
          bp_n = rdata;
          sp_n = base_ptr - 16'd1;
          pc_n = rdata2;
        end
        acu_pkg::OP_HALT: begin
          for (int i = 0; i < 4; i++) g_n[i] = 16'd0;
          ac_n = 16'd0;
          sp_n = stack_start;
          bp_n = stack_start;
          pc_n = code_start;
          st_n = acu_pkg::ST_HALT;
        end
        default: ;
      endcase
    end
  end
  assign ret_pending = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      clearing  <= 1'b1;
      clr_addr  <= '0;
      for (int i = 0; i < 4; i++) gen_regs[i] <= 16'd0;
      accumulator     <= 16'd0;
      code_start      <= acu_pkg::CODE_START_RST;
      stack_start     <= acu_pkg::STACK_START_RST;
      stack_ptr       <= acu_pkg::STACK_START_RST;
      base_ptr        <= acu_pkg::STACK_START_RST;
      program_counter <= acu_pkg::CODE_START_RST;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (&clr_addr) clearing <= 1'b0;
      end
      if (cfg_we) begin
        if (cfg_index == acu_pkg::CFG_CODE_START) code_start <= cfg_wdata;
        else                                      stack_start <= cfg_wdata;
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (q_valid && q_ready) begin
        busy <= 1'b1;
      end else if (busy && !ret_pending) begin
        busy <= 1'b0;
        for (int i = 0; i < 4; i++) gen_regs[i] <= g_n[i];
        accumulator     <= ac_n;
        stack_ptr       <= sp_n;
        base_ptr        <= bp_n;
        program_counter <= pc_n;
        out_valid       <= 1'b1;
        out_data        <= '{status: st_n, next_pc: pc_n, acc_value: ac_n,
                             stack_value: sp_n, frame_value: bp_n};
      end
    end
  end
endmodule
`default_nettype wire

FILE: src/accumulator_cpu_execute_unit.sv
// Top level of the accumulator CPU execute unit.
// Depends on acu_pkg, acu_if, acu_front and acu_back.
//
// Usage:
//   instr  - sink channel; one transaction is one decoded instruction.
//   result - source channel; one transaction per instruction with the
//            status and the PC, AC, SP and BP after it.
//   cfg    - register writes: index 0 code_start, 1 stack_start. Write
//            only while no instruction is outstanding.
// Timing: the back end runs each instruction through phase 0 and phase 1 (call
//   writes one stack word in each phase, ret reads both saved words in phase 0),
//   and takes no new instruction until the current one is done. A result is
//   registered after its instruction has passed the queue, phase 0 and phase 1.
// Front end: classifies operand errors and holds up to two instructions.
// Reset (rst, synchronous): registers take their reset values, code_start
//   0x10 and stack_start 0x100; the queue and output empty. Data memory is
//   then zeroed one word per cycle over all 65536 words, while instr stalls after
//   two transactions. Halt keeps memory.
// Stall: a held result blocks the back end; the queue then fills and
//   instr.ready drops.
`default_nettype none
module accumulator_cpu_execute_unit (
  input  wire          clk,
  input  wire          rst,
  acu_instr_if.sink    instr,
  acu_result_if.source result,
  acu_cfg_if.sink      cfg
);
  logic              q_valid, q_ready;
  acu_pkg::decoded_t q_data;

  assign cfg.ready = 1'b1;

  acu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (instr.valid),
    .in_ready (instr.ready),
    .in_data  (instr.data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_data)
  );

  acu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .cfg_we    (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_wdata (cfg.wdata),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result.data)
  );
endmodule
`default_nettype wire
